[src/pctbt_pkg.sv]
// Shared types and constants of the per-client token bucket table.
// Used by the controller, the datapath and the top level.
package pctbt_pkg;

  typedef enum logic [1:0] {
    CMD_CHECK = 2'd0,
    CMD_RESET = 2'd1,
    CMD_QUERY = 2'd2
  } command_e;

  localparam logic [1:0] CFG_REFILL = 2'd0;
  localparam logic [1:0] CFG_BURST  = 2'd1;
  localparam logic [1:0] CFG_SLOTS  = 2'd2;

  localparam logic [15:0] REFILL_RESET = 16'd100;
  localparam logic [15:0] BURST_RESET  = 16'd100;
  localparam logic [6:0]  SLOTS_RESET  = 7'd64;
  localparam logic [41:0] MS_PER_S     = 42'd1000;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] client_key;
    logic [31:0] now_seconds;
  } in_t;

  typedef struct packed {
    logic        status;
    logic [15:0] remaining_tokens;
    logic [41:0] last_update_ms;
  } out_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] key;
    logic [15:0] tokens;
    logic [15:0] capacity;
    logic [15:0] rate;
    logic [31:0] stamp;
  } slot_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_LOAD,
    ST_CALC,
    ST_WRITE
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic clr_en;
    logic accept;
    logic scan;
    logic fetch;
    logic load;
    logic calc;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    logic clr_last;
    logic scan_done;
  } stat_t;

endpackage

[src/per_client_token_bucket_table_core.sv]
// Per-client token bucket table. After reset the block clears the slot RAM
// and accepts no item until that is done; configuration writes are taken at
// any time. An item is worked in steps: a scan of the slot RAM, one read per
// cycle over the first N slots, N being the active slot count (the CFG_SLOTS
// register clamped to 1..TABLE_SLOTS), for the key, a free slot and the
// oldest stamp; then fetch, load, multiply and write-back. The next item is
// taken in the cycle after the write-back at the earliest. One item is in
// work at a time; while a finished word waits unread in the output register
// the write-back step holds and no new item is taken. Depends on pctbt_pkg,
// pctbt_ctrl, pctbt_dp and pctbt_ram.
module per_client_token_bucket_table_core #(
  parameter int TABLE_SLOTS = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pctbt_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pctbt_pkg::out_t out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  logic [15:0]     cfg_data_i
);

  pctbt_pkg::ctrl_t ctrl;
  pctbt_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  pctbt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  pctbt_dp #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (out_data_o)
  );

endmodule

[src/pctbt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pctbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/pctbt_ctrl.sv]
// Controller state machine of the token bucket table.
// Depends on pctbt_pkg; drives pctbt_dp through ctrl_t and reads stat_t.
module pctbt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  pctbt_pkg::stat_t stat_i,
  output pctbt_pkg::ctrl_t ctrl_o
);

  pctbt_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pctbt_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      pctbt_pkg::ST_CLEAR: begin
        ctrl_o.clr_en = 1'b1;
        if (stat_i.clr_last) state_d = pctbt_pkg::ST_IDLE;
      end
      pctbt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.accept = 1'b1;
          state_d       = pctbt_pkg::ST_SCAN;
        end
      end
      pctbt_pkg::ST_SCAN: begin
        ctrl_o.scan = 1'b1;
        if (stat_i.scan_done) state_d = pctbt_pkg::ST_FETCH;
      end
      pctbt_pkg::ST_FETCH: begin
        ctrl_o.fetch = 1'b1;
        state_d      = pctbt_pkg::ST_LOAD;
      end
      pctbt_pkg::ST_LOAD: begin
        ctrl_o.load = 1'b1;
        state_d     = pctbt_pkg::ST_CALC;
      end
      pctbt_pkg::ST_CALC: begin
        ctrl_o.calc = 1'b1;
        state_d     = pctbt_pkg::ST_WRITE;
      end
      pctbt_pkg::ST_WRITE: begin
        // hold until the output register can take the word
        if (out_free) begin
          ctrl_o.finish = 1'b1;
          state_d       = pctbt_pkg::ST_IDLE;
        end
      end
      default: state_d = pctbt_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.finish) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;

  a_accept_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == pctbt_pkg::ST_SCAN))
    else $error("accepted word did not start a scan");

  a_finish_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.finish |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote a pending word");

  a_finish_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.finish |=> out_valid_q)
    else $error("finished result not presented");

endmodule

[src/pctbt_dp.sv]
// Datapath of the token bucket table: config registers, slot RAM, scan,
// refill arithmetic and result register. Depends on pctbt_pkg and pctbt_ram.
module pctbt_dp #(
  parameter int TABLE_SLOTS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pctbt_pkg::ctrl_t  ctrl_i,
  output pctbt_pkg::stat_t  stat_o,
  input  pctbt_pkg::in_t    in_data_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  output pctbt_pkg::out_t   out_data_o
);

  localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CW = $clog2(TABLE_SLOTS + 1);
  localparam int LW = (CW > 7) ? CW : 7;
  localparam int SW = $bits(pctbt_pkg::slot_t);

  logic [15:0] refill_q, burst_q;
  logic [6:0]  slots_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refill_q <= pctbt_pkg::REFILL_RESET;
      burst_q  <= pctbt_pkg::BURST_RESET;
      slots_q  <= pctbt_pkg::SLOTS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pctbt_pkg::CFG_REFILL: refill_q <= cfg_data_i;
        pctbt_pkg::CFG_BURST:  burst_q  <= cfg_data_i;
        pctbt_pkg::CFG_SLOTS:  slots_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // active slot count, clamped to 1..TABLE_SLOTS
  logic [LW-1:0] slots_ext, limit;
  assign slots_ext = LW'(slots_q);
  always_comb begin
    if (slots_ext == '0) limit = LW'(1);
    else if (slots_ext > LW'(TABLE_SLOTS)) limit = LW'(TABLE_SLOTS);
    else limit = slots_ext;
  end

  // item registers
  logic [1:0]  cmd_q;
  logic [63:0] key_q;
  logic [31:0] now_q;

  // scan state
  logic [LW-1:0] iss_q;
  logic          rvalid_q;
  logic [AW-1:0] ridx_q;
  logic          hit_q, free_q;
  logic [AW-1:0] hit_idx_q, free_idx_q, old_idx_q, sel_q;
  logic [31:0]   oldest_q;
  logic [AW-1:0] clr_q;

  pctbt_pkg::slot_t rdata, ent_q, wr_ent;
  logic [SW-1:0]    rdata_raw;
  logic             issue;
  logic [AW-1:0]    sel_d;
  logic [31:0]      elapsed_q;
  logic [47:0]      prod_q;
  logic [41:0]      ms_q;
  pctbt_pkg::out_t  res_q, res_d;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [SW-1:0] wdata;

  assign rdata = pctbt_pkg::slot_t'(rdata_raw);
  assign issue = ctrl_i.scan && (iss_q < limit);

  always_comb begin
    if (cmd_q == pctbt_pkg::CMD_CHECK) begin
      if (hit_q) sel_d = hit_idx_q;
      else if (free_q) sel_d = free_idx_q;
      else sel_d = old_idx_q;
    end else begin
      sel_d = hit_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q    <= '0;
      iss_q    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (ctrl_i.clr_en) clr_q <= clr_q + AW'(1);
      if (ctrl_i.accept) begin
        iss_q    <= '0;
        rvalid_q <= 1'b0;
      end else if (ctrl_i.scan) begin
        rvalid_q <= issue;
        if (issue) iss_q <= iss_q + LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      cmd_q     <= in_data_i.command;
      key_q     <= in_data_i.client_key;
      now_q     <= in_data_i.now_seconds;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      hit_idx_q <= '0;
      free_idx_q <= '0;
      old_idx_q <= '0;
      oldest_q  <= in_data_i.now_seconds;
    end
    if (ctrl_i.scan) begin
      ridx_q <= iss_q[AW-1:0];
      if (rvalid_q) begin
        if (rdata.valid && rdata.key == key_q && !hit_q) begin
          hit_q     <= 1'b1;
          hit_idx_q <= ridx_q;
        end
        if (!rdata.valid && !free_q) begin
          free_q     <= 1'b1;
          free_idx_q <= ridx_q;
        end
        if (rdata.valid && rdata.stamp < oldest_q) begin
          oldest_q  <= rdata.stamp;
          old_idx_q <= ridx_q;
        end
      end
    end
    if (ctrl_i.fetch) sel_q <= sel_d;
    if (ctrl_i.load) begin
      if (cmd_q == pctbt_pkg::CMD_CHECK && !hit_q) begin
        ent_q.valid    <= 1'b1;
        ent_q.key      <= key_q;
        ent_q.tokens   <= burst_q;
        ent_q.capacity <= burst_q;
        ent_q.rate     <= refill_q;
        ent_q.stamp    <= now_q;
        elapsed_q      <= '0;
      end else begin
        ent_q     <= rdata;
        elapsed_q <= (now_q > rdata.stamp) ? now_q - rdata.stamp : 32'd0;
      end
    end
    if (ctrl_i.calc) begin
      prod_q <= 48'(elapsed_q) * 48'(ent_q.rate);
      ms_q   <= 42'(ent_q.stamp) * pctbt_pkg::MS_PER_S;
    end
    if (ctrl_i.finish) res_q <= res_d;
  end

  // refill, clamp, spend and build the result
  logic [48:0] tok_sum;
  logic [15:0] tok_clamp;
  logic        wr_need;
  always_comb begin
    tok_sum   = 49'(ent_q.tokens) + 49'(prod_q);
    tok_clamp = (tok_sum > 49'(ent_q.capacity)) ? ent_q.capacity : tok_sum[15:0];
    wr_ent    = ent_q;
    wr_ent.stamp = now_q;
    res_d     = '0;
    wr_need   = 1'b0;
    priority if (cmd_q == pctbt_pkg::CMD_CHECK) begin
      wr_need = 1'b1;
      if (tok_clamp != '0) begin
        wr_ent.tokens = tok_clamp - 16'd1;
      end else begin
        wr_ent.tokens = tok_clamp;
        res_d.status  = 1'b1;
      end
    end else if (cmd_q == pctbt_pkg::CMD_RESET) begin
      wr_need       = hit_q;
      wr_ent.tokens = ent_q.capacity;
    end else if (cmd_q == pctbt_pkg::CMD_QUERY) begin
      if (hit_q) begin
        res_d.remaining_tokens = ent_q.tokens;
        res_d.last_update_ms   = ms_q;
      end else begin
        res_d.status = 1'b1;
      end
    end else begin
      res_d.status = 1'b1;
    end
  end

  always_comb begin
    we    = ctrl_i.clr_en || (ctrl_i.finish && wr_need);
    waddr = ctrl_i.clr_en ? clr_q : sel_q;
    wdata = ctrl_i.clr_en ? '0 : SW'(wr_ent);
    re    = issue || ctrl_i.fetch;
    raddr = ctrl_i.fetch ? sel_d : iss_q[AW-1:0];
  end

  pctbt_ram #(
    .WIDTH (SW),
    .DEPTH (TABLE_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  assign stat_o.clr_last  = (clr_q == AW'(TABLE_SLOTS - 1));
  assign stat_o.scan_done = (iss_q >= limit) && !rvalid_q;
  assign out_data_o       = res_q;

  a_no_write_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.scan |-> !we)
    else $error("slot RAM written during scan");

  a_scan_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.scan |-> (iss_q <= limit))
    else $error("scan ran past the active slot count");

  a_fetch_after_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.fetch |-> ((iss_q >= limit) && !rvalid_q))
    else $error("fetch started before the scan completed");

endmodule
